// ===== rtl/sorted_priority_queue_defines.svh =====
// Assertion macros shared by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is active.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that also holds while reset is active.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

  // Field widths of the stream payloads.
  localparam int OPCODE_W    = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int OUT_VALUE_W = 32;

  // Operation codes carried by each input transaction.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ          = 3'd0,
    OP_DEQ_HEAD     = 3'd1,
    OP_DEQ_EXACT    = 3'd2,
    OP_DEQ_AT_LEAST = 3'd3,
    OP_PEEK         = 3'd4
  } spq_op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } spq_status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } spq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the request and the per-entry compares.
    logic commit;   // Shift the entries and load the result register.
  } spq_cmd_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller state machine for the sorted priority queue.
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_cmd_t cmd_o
);

  spq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_UPDATE: begin
        cmd_o.commit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // The result register is full from a commit until its transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/spq_dpath.sv =====
// Datapath of the sorted priority queue: entry cells, compares, shifts and result register.
module spq_dpath import spq_pkg::*; #(
  parameter  int DEPTH      = 16,
  parameter  int VALUE_BITS = 32,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spq_cmd_t               cmd_i,
  input  logic [OPCODE_W-1:0]    in_opcode_i,
  input  logic [IN_VALUE_W-1:0]  in_value_i,
  input  logic [PRIO_W-1:0]      in_priority_i,
  output logic [STATUS_W-1:0]    res_status_o,
  output logic [OUT_VALUE_W-1:0] res_value_o,
  output logic [PRIO_W-1:0]      res_priority_o,
  output logic [CW-1:0]          res_count_o
);

  // Entry cells, index 0 is the head.
  logic [VALUE_BITS-1:0] val_q [DEPTH];
  logic [VALUE_BITS-1:0] val_d [DEPTH];
  logic [PRIO_W-1:0]     pri_q [DEPTH];
  logic [PRIO_W-1:0]     pri_d [DEPTH];
  logic [VALUE_BITS-1:0] val_up [DEPTH];
  logic [VALUE_BITS-1:0] val_dn [DEPTH];
  logic [PRIO_W-1:0]     pri_up [DEPTH];
  logic [PRIO_W-1:0]     pri_dn [DEPTH];
  logic [CW-1:0]         count_q, count_d;

  // Captured request and compare flags.
  logic [OPCODE_W-1:0]   op_q;
  logic [IN_VALUE_W-1:0] req_val_q;
  logic [PRIO_W-1:0]     req_pri_q;
  logic [DEPTH-1:0]      ge_q, gt_q, eq_q;
  logic [DEPTH-1:0]      ge_d, gt_d, eq_d;

  // Selection and shift masks.
  logic [DEPTH-1:0]      valid, first_ge, tail_sel, ins_mask, ins_prev, sel, rm_mask;
  logic                  do_ins, do_rm, hit;
  spq_status_e           status_d;
  logic [VALUE_BITS-1:0] picked_val, new_val;
  logic [PRIO_W-1:0]     picked_pri;
  logic [IN_VALUE_W+VALUE_BITS-1:0]  new_ext;
  logic [OUT_VALUE_W+VALUE_BITS-1:0] out_ext;

  // Result register.
  logic [STATUS_W-1:0]    res_status_q;
  logic [OUT_VALUE_W-1:0] res_value_q;
  logic [PRIO_W-1:0]      res_pri_q;
  logic [CW-1:0]          res_count_q;

  // Per-cell occupancy and compares against the incoming priority.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      valid[k]    = CW'(k) < count_q;
      ge_d[k]     = valid[k] && (pri_q[k] >= in_priority_i);
      gt_d[k]     = valid[k] && (pri_q[k] >  in_priority_i);
      eq_d[k]     = valid[k] && (pri_q[k] == in_priority_i);
      tail_sel[k] = CW'(k + 1) == count_q;
      ins_mask[k] = gt_q[k] || (CW'(k) == count_q);
    end
  end

  assign first_ge = ge_q & ~(ge_q << 1);
  assign ins_prev = ins_mask << 1;

  // Capture the request together with the compare flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_opcode_i;
      req_val_q <= in_value_i;
      req_pri_q <= in_priority_i;
      ge_q      <= ge_d;
      gt_q      <= gt_d;
      eq_q      <= eq_d;
    end
  end

  // Decode the operation against the registered flags.
  always_comb begin
    status_d = ST_NONE;
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    hit      = 1'b0;
    sel      = '0;
    rm_mask  = '0;
    unique case (op_q)
      OP_ENQ: begin
        if (count_q == CW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          do_ins   = 1'b1;
        end
      end
      OP_DEQ_HEAD: begin
        sel     = DEPTH'(valid[0]);
        rm_mask = '1;
        if (valid[0]) begin
          status_d = ST_OK;
          do_rm    = 1'b1;
          hit      = 1'b1;
        end
      end
      OP_DEQ_EXACT: begin
        sel     = first_ge;
        rm_mask = ge_q;
        if (|(first_ge & eq_q)) begin
          status_d = ST_OK;
          do_rm    = 1'b1;
          hit      = 1'b1;
        end
      end
      OP_DEQ_AT_LEAST: begin
        sel     = first_ge;
        rm_mask = ge_q;
        if (|ge_q) begin
          status_d = ST_OK;
          do_rm    = 1'b1;
          hit      = 1'b1;
        end
      end
      OP_PEEK: begin
        sel = tail_sel;
        if (count_q != '0) begin
          status_d = ST_OK;
          hit      = 1'b1;
        end
      end
      default: begin
        status_d = ST_NONE;
      end
    endcase
  end

  // Read out the selected entry through a one-hot OR.
  always_comb begin
    picked_val = '0;
    picked_pri = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (sel[k]) begin
        picked_val = picked_val | val_q[k];
        picked_pri = picked_pri | pri_q[k];
      end
    end
  end

  assign new_ext = {VALUE_BITS'(0), req_val_q};
  assign new_val = new_ext[VALUE_BITS-1:0];
  assign out_ext = {OUT_VALUE_W'(0), picked_val};

  // Neighbor taps for closing a gap and for opening one.
  always_comb begin
    for (int k = 0; k < DEPTH - 1; k++) begin
      val_up[k] = val_q[k+1];
      pri_up[k] = pri_q[k+1];
    end
    val_up[DEPTH-1] = val_q[DEPTH-1];
    pri_up[DEPTH-1] = pri_q[DEPTH-1];
    val_dn[0] = new_val;
    pri_dn[0] = req_pri_q;
    for (int k = 1; k < DEPTH; k++) begin
      val_dn[k] = val_q[k-1];
      pri_dn[k] = pri_q[k-1];
    end
  end

  // Each cell holds, takes its upper neighbor, its lower neighbor or the new entry.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      val_d[k] = val_q[k];
      pri_d[k] = pri_q[k];
      if (do_rm && rm_mask[k]) begin
        val_d[k] = val_up[k];
        pri_d[k] = pri_up[k];
      end else if (do_ins && ins_mask[k]) begin
        if (ins_prev[k]) begin
          val_d[k] = val_dn[k];
          pri_d[k] = pri_dn[k];
        end else begin
          val_d[k] = new_val;
          pri_d[k] = req_pri_q;
        end
      end
    end
  end

  // Entry count after the operation.
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rm) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      val_q <= val_d;
      pri_q <= pri_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= status_d;
      res_value_q  <= hit ? out_ext[OUT_VALUE_W-1:0] : '0;
      res_pri_q    <= hit ? picked_pri : '0;
      res_count_q  <= count_d;
    end
  end

  assign res_status_o   = res_status_q;
  assign res_value_o    = res_value_q;
  assign res_priority_o = res_pri_q;
  assign res_count_o    = res_count_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue with stream ports.
// A transaction first captures the request and compares every entry in parallel,
// then shifts the entries and loads the result register; this commit waits while an
// earlier result is still unaccepted. No new request is taken before the current one commits.
// Reset empties the queue and the result register; entry storage is not cleared.
module sorted_priority_queue import spq_pkg::*; #(
  parameter  int DEPTH      = 16,
  parameter  int VALUE_BITS = 32,
  localparam int CW         = $clog2(DEPTH + 1),
  localparam int IN_W       = ((OPCODE_W + IN_VALUE_W + PRIO_W + 7) / 8) * 8,
  localparam int OUT_RAW_W  = STATUS_W + OUT_VALUE_W + PRIO_W + CW,
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // opcode, value, priority_req
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // status, out_value, out_priority, count
);

  localparam int VAL_LO = OPCODE_W;
  localparam int PRI_LO = OPCODE_W + IN_VALUE_W;

  spq_cmd_t               cmd;
  logic [STATUS_W-1:0]    res_status;
  logic [OUT_VALUE_W-1:0] res_value;
  logic [PRIO_W-1:0]      res_priority;
  logic [CW-1:0]          res_count;

  // Sequencing of capture and commit.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Entry cells and result register.
  spq_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_opcode_i    (s_axis_tdata[OPCODE_W-1:0]),
    .in_value_i     (s_axis_tdata[VAL_LO +: IN_VALUE_W]),
    .in_priority_i  (s_axis_tdata[PRI_LO +: PRIO_W]),
    .res_status_o   (res_status),
    .res_value_o    (res_value),
    .res_priority_o (res_priority),
    .res_count_o    (res_count)
  );

  // Pack the result fields, status in the lowest bits.
  assign m_axis_tdata = OUT_W'({res_count, res_priority, res_value, res_status});

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level assertions for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker import spq_pkg::*; #(
  parameter  int DEPTH     = 16,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int OUT_RAW_W = STATUS_W + OUT_VALUE_W + PRIO_W + CW,
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int VAL_LO = STATUS_W;
  localparam int PRI_LO = STATUS_W + OUT_VALUE_W;
  localparam int CNT_LO = STATUS_W + OUT_VALUE_W + PRIO_W;

  logic [STATUS_W-1:0] st;
  logic [CW-1:0]       cnt;
  logic                fields_zero;

  assign st          = m_axis_tdata[STATUS_W-1:0];
  assign cnt         = m_axis_tdata[CNT_LO +: CW];
  assign fields_zero = (m_axis_tdata[VAL_LO +: OUT_VALUE_W] == '0) &&
                       (m_axis_tdata[PRI_LO +: PRIO_W] == '0);

  // A pending result stays offered until its transaction completes.
  `SPQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // Only one request is in work: input is not taken in the cycle after a transaction.
  `SPQ_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken while one is in work")

  // The reported count never exceeds the capacity, and a full report means a full queue.
  `SPQ_ASSERT(a_count_range, m_axis_tvalid |-> (cnt <= CW'(DEPTH)) && ((st != ST_FULL) || (cnt == CW'(DEPTH))), "count out of range")

  // Any result with a status other than OK carries zero value and priority.
  `SPQ_ASSERT(a_zero_fields, m_axis_tvalid && (st != ST_OK) |-> fields_zero, "nonzero fields on a failed operation")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
